@@ rtl/gpts_pkg.sv @@
// Shared types, constants and helpers for the greedy pair target selector.
// No dependencies.
package gpts_pkg;

    localparam int COORD_W  = 16;
    localparam int SLOT_W   = 10;
    localparam int WEIGHT_W = 10;
    localparam int LEG_W    = 17;
    localparam int GAIN_W   = 20;
    localparam int SQ_W     = 2 * LEG_W;
    localparam int LEN_W    = LEG_W + 1;
    localparam int KSUM_W   = WEIGHT_W + 1;
    localparam int MUL_W    = LEN_W;
    localparam int PROD_W   = 2 * MUL_W;

    localparam int NUM_TARGETS_DEF = 1024;
    localparam int MAX_WEIGHT_DEF  = 1000;

    localparam logic [GAIN_W-1:0]  GAIN_MAX    = '1;
    localparam logic [COORD_W-1:0] AGENT_RESET = COORD_W'(1) << (COORD_W - 1);

    localparam logic [1:0] KIND_LOAD  = 2'd0;
    localparam logic [1:0] KIND_STEP  = 2'd1;
    localparam logic [1:0] KIND_PLACE = 2'd2;

    localparam logic STATUS_CHOSEN  = 1'b0;
    localparam logic STATUS_NO_PAIR = 1'b1;

    typedef struct packed {
        logic [1:0]          kind;
        logic [SLOT_W-1:0]   target_slot;
        logic [COORD_W-1:0]  pos_x;
        logic [COORD_W-1:0]  pos_y;
        logic [WEIGHT_W-1:0] weight;
    } in_item_t;

    typedef struct packed {
        logic [SLOT_W-1:0]   chosen_index;
        logic [COORD_W-1:0]  chosen_x;
        logic [COORD_W-1:0]  chosen_y;
        logic [LEG_W-1:0]    leg_length;
        logic [WEIGHT_W-1:0] chosen_weight;
        logic [GAIN_W-1:0]   gain_so_far;
        logic                status;
        logic                last;
    } out_item_t;

    typedef struct packed {
        logic [COORD_W-1:0]  x;
        logic [COORD_W-1:0]  y;
        logic [WEIGHT_W-1:0] w;
    } entry_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_I_RD,
        ST_I_CHK,
        ST_W_RD,
        ST_W_CHK,
        ST_SQX,
        ST_SQY,
        ST_SUM,
        ST_ROOT,
        ST_CMP_A,
        ST_CMP_B,
        ST_CMP_C,
        ST_OUT_A,
        ST_OUT_B
    } state_t;

    function automatic logic [GAIN_W-1:0] sat_add(input logic [GAIN_W-1:0] g,
                                                   input logic [WEIGHT_W-1:0] k);
        logic [GAIN_W:0] s;
        s = {1'b0, g} + (GAIN_W + 1)'(k);
        return s[GAIN_W] ? GAIN_MAX : s[GAIN_W-1:0];
    endfunction

    function automatic logic [COORD_W-1:0] abs_diff(input logic [COORD_W-1:0] a,
                                                    input logic [COORD_W-1:0] b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

endpackage

@@ rtl/greedy_pair_target_select_core.sv @@
// Greedy pair target selector: sequencer over the target table, one shared
// multiplier and one bit-serial square root unit.
// Load and place items are taken in the idle state. A step reads each entry of the
// outer scan; each live row takes its first leg from the agent, then each entry
// of its inner scan; each live pair runs two squares, sum, root wait, two cross
// products, compare. One or two result states end the step; results are registered.
// After reset the table is cleared entry by entry, busy high.
// Results are strobed once by result_valid; the receiver cannot stall.
module greedy_pair_target_select_core #(
    parameter int NUM_TARGETS = gpts_pkg::NUM_TARGETS_DEF,
    parameter int MAX_WEIGHT  = gpts_pkg::MAX_WEIGHT_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  gpts_pkg::in_item_t    cmd,
    output logic                  busy,
    output logic                  result_valid,
    output gpts_pkg::out_item_t   result
);

    localparam int IDX_W = (NUM_TARGETS > 1) ? $clog2(NUM_TARGETS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_TARGETS - 1);

    gpts_pkg::state_t state_reg, state_next;

    logic [IDX_W-1:0] i_reg, w_reg;
    logic [gpts_pkg::COORD_W-1:0]  agent_x_reg, agent_y_reg;
    logic [gpts_pkg::GAIN_W-1:0]   gain_reg;
    logic                          found_reg, pair_reg;
    logic [gpts_pkg::COORD_W-1:0]  xi_reg, yi_reg, xw_reg, yw_reg, dx_reg, dy_reg;
    logic [gpts_pkg::WEIGHT_W-1:0] ki_reg, kw_reg;
    logic [gpts_pkg::LEG_W-1:0]    l1_reg, l2_reg;
    logic [gpts_pkg::SQ_W-1:0]     sq_reg;
    logic [gpts_pkg::PROD_W-1:0]   lhs_reg;
    logic [gpts_pkg::LEN_W-1:0]    best_len_reg;
    logic [gpts_pkg::KSUM_W-1:0]   best_k_reg;
    logic [IDX_W-1:0]              bi_reg, bw_reg;
    logic [gpts_pkg::COORD_W-1:0]  bxi_reg, byi_reg, bxw_reg, byw_reg;
    logic [gpts_pkg::WEIGHT_W-1:0] bki_reg, bkw_reg;
    logic [gpts_pkg::LEG_W-1:0]    bl1_reg, bl2_reg;
    logic [gpts_pkg::GAIN_W-1:0]   gain1;

    logic                        accept;
    logic                        we;
    logic [IDX_W-1:0]            waddr, raddr;
    gpts_pkg::entry_t            wdata, rdata;
    logic [gpts_pkg::MUL_W-1:0]  mul_a, mul_b;
    logic [gpts_pkg::PROD_W-1:0] prod;
    logic                        sq_go, sq_done;
    logic [gpts_pkg::SQ_W-1:0]   radicand;
    logic [gpts_pkg::LEG_W-1:0]  root;
    logic [gpts_pkg::LEN_W-1:0]  len;
    logic [gpts_pkg::KSUM_W-1:0] ks;
    logic                        better;
    logic [gpts_pkg::WEIGHT_W-1:0] load_w;
    logic                        slot_ok;

    gpts_store #(.NUM_TARGETS(NUM_TARGETS), .IDX_W(IDX_W)) u_store (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    gpts_mul u_mul (
        .clk      (clk),
        .a        (mul_a),
        .b        (mul_b),
        .prod_reg (prod)
    );

    gpts_isqrt u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .go       (sq_go),
        .radicand (radicand),
        .done_reg (sq_done),
        .root_reg (root)
    );

    assign busy     = (state_reg != gpts_pkg::ST_IDLE);
    assign accept   = start && !busy;
    assign len      = gpts_pkg::LEN_W'(l1_reg) + gpts_pkg::LEN_W'(l2_reg);
    assign ks       = gpts_pkg::KSUM_W'(ki_reg) + gpts_pkg::KSUM_W'(kw_reg);
    assign better   = !found_reg || (lhs_reg < prod);
    assign radicand = sq_reg + gpts_pkg::SQ_W'(prod);
    assign sq_go    = (state_reg == gpts_pkg::ST_SUM);
    assign slot_ok  = 32'(cmd.target_slot) < NUM_TARGETS;
    assign load_w   = (32'(cmd.weight) > MAX_WEIGHT) ?
                      gpts_pkg::WEIGHT_W'(MAX_WEIGHT) : cmd.weight;
    assign gain1    = gpts_pkg::sat_add(gain_reg, bki_reg);

    always_comb
    begin
        we    = 1'b0;
        waddr = i_reg;
        wdata = '0;
        raddr = i_reg;
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            gpts_pkg::ST_CLEAR:
            begin
                we = 1'b1;
            end
            gpts_pkg::ST_IDLE:
            begin
                we    = accept && (cmd.kind == gpts_pkg::KIND_LOAD) && slot_ok;
                waddr = IDX_W'(cmd.target_slot);
                wdata = '{x: cmd.pos_x, y: cmd.pos_y, w: load_w};
            end
            gpts_pkg::ST_W_RD:
            begin
                raddr = w_reg;
            end
            gpts_pkg::ST_SQX:
            begin
                mul_a = gpts_pkg::MUL_W'(dx_reg);
                mul_b = gpts_pkg::MUL_W'(dx_reg);
            end
            gpts_pkg::ST_SQY:
            begin
                mul_a = gpts_pkg::MUL_W'(dy_reg);
                mul_b = gpts_pkg::MUL_W'(dy_reg);
            end
            gpts_pkg::ST_CMP_A:
            begin
                mul_a = len;
                mul_b = gpts_pkg::MUL_W'(best_k_reg);
            end
            gpts_pkg::ST_CMP_B:
            begin
                mul_a = best_len_reg;
                mul_b = gpts_pkg::MUL_W'(ks);
            end
            gpts_pkg::ST_OUT_A:
            begin
                we    = found_reg;
                waddr = bi_reg;
                wdata = '{x: bxi_reg, y: byi_reg, w: '0};
            end
            gpts_pkg::ST_OUT_B:
            begin
                we    = 1'b1;
                waddr = bw_reg;
                wdata = '{x: bxw_reg, y: byw_reg, w: '0};
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            gpts_pkg::ST_CLEAR:
            begin
                if (i_reg == LAST_IDX)
                begin
                    state_next = gpts_pkg::ST_IDLE;
                end
            end
            gpts_pkg::ST_IDLE:
            begin
                if (accept && (cmd.kind == gpts_pkg::KIND_STEP))
                begin
                    state_next = gpts_pkg::ST_I_RD;
                end
            end
            gpts_pkg::ST_I_RD:
            begin
                state_next = gpts_pkg::ST_I_CHK;
            end
            gpts_pkg::ST_I_CHK:
            begin
                if (rdata.w != '0)
                begin
                    state_next = gpts_pkg::ST_SQX;
                end
                else if (i_reg == LAST_IDX)
                begin
                    state_next = gpts_pkg::ST_OUT_A;
                end
                else
                begin
                    state_next = gpts_pkg::ST_I_RD;
                end
            end
            gpts_pkg::ST_W_RD:
            begin
                state_next = gpts_pkg::ST_W_CHK;
            end
            gpts_pkg::ST_W_CHK:
            begin
                if ((w_reg != i_reg) && (rdata.w != '0))
                begin
                    state_next = gpts_pkg::ST_SQX;
                end
                else if (w_reg != LAST_IDX)
                begin
                    state_next = gpts_pkg::ST_W_RD;
                end
                else if (i_reg != LAST_IDX)
                begin
                    state_next = gpts_pkg::ST_I_RD;
                end
                else
                begin
                    state_next = gpts_pkg::ST_OUT_A;
                end
            end
            gpts_pkg::ST_SQX:
            begin
                state_next = gpts_pkg::ST_SQY;
            end
            gpts_pkg::ST_SQY:
            begin
                state_next = gpts_pkg::ST_SUM;
            end
            gpts_pkg::ST_SUM:
            begin
                state_next = gpts_pkg::ST_ROOT;
            end
            gpts_pkg::ST_ROOT:
            begin
                if (sq_done)
                begin
                    state_next = pair_reg ? gpts_pkg::ST_CMP_A : gpts_pkg::ST_W_RD;
                end
            end
            gpts_pkg::ST_CMP_A:
            begin
                state_next = gpts_pkg::ST_CMP_B;
            end
            gpts_pkg::ST_CMP_B:
            begin
                state_next = gpts_pkg::ST_CMP_C;
            end
            gpts_pkg::ST_CMP_C:
            begin
                if (w_reg != LAST_IDX)
                begin
                    state_next = gpts_pkg::ST_W_RD;
                end
                else if (i_reg != LAST_IDX)
                begin
                    state_next = gpts_pkg::ST_I_RD;
                end
                else
                begin
                    state_next = gpts_pkg::ST_OUT_A;
                end
            end
            gpts_pkg::ST_OUT_A:
            begin
                state_next = found_reg ? gpts_pkg::ST_OUT_B : gpts_pkg::ST_IDLE;
            end
            gpts_pkg::ST_OUT_B:
            begin
                state_next = gpts_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = gpts_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= gpts_pkg::ST_CLEAR;
            i_reg        <= '0;
            w_reg        <= '0;
            agent_x_reg  <= gpts_pkg::AGENT_RESET;
            agent_y_reg  <= gpts_pkg::AGENT_RESET;
            gain_reg     <= '0;
            found_reg    <= 1'b0;
            pair_reg     <= 1'b0;
            result_valid <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            result_valid <= 1'b0;
            unique case (state_reg)
                gpts_pkg::ST_CLEAR:
                begin
                    i_reg <= (i_reg == LAST_IDX) ? '0 : i_reg + 1'b1;
                end
                gpts_pkg::ST_IDLE:
                begin
                    if (accept && (cmd.kind == gpts_pkg::KIND_PLACE))
                    begin
                        agent_x_reg <= cmd.pos_x;
                        agent_y_reg <= cmd.pos_y;
                        gain_reg    <= '0;
                    end
                    if (accept && (cmd.kind == gpts_pkg::KIND_STEP))
                    begin
                        i_reg     <= '0;
                        found_reg <= 1'b0;
                    end
                end
                gpts_pkg::ST_I_CHK:
                begin
                    pair_reg <= 1'b0;
                    if ((rdata.w == '0) && (i_reg != LAST_IDX))
                    begin
                        i_reg <= i_reg + 1'b1;
                    end
                end
                gpts_pkg::ST_ROOT:
                begin
                    if (sq_done && !pair_reg)
                    begin
                        w_reg <= '0;
                    end
                end
                gpts_pkg::ST_W_CHK:
                begin
                    pair_reg <= 1'b1;
                    if (!((w_reg != i_reg) && (rdata.w != '0)))
                    begin
                        if (w_reg != LAST_IDX)
                        begin
                            w_reg <= w_reg + 1'b1;
                        end
                        else if (i_reg != LAST_IDX)
                        begin
                            i_reg <= i_reg + 1'b1;
                        end
                    end
                end
                gpts_pkg::ST_CMP_C:
                begin
                    if (better)
                    begin
                        found_reg <= 1'b1;
                    end
                    if (w_reg != LAST_IDX)
                    begin
                        w_reg <= w_reg + 1'b1;
                    end
                    else if (i_reg != LAST_IDX)
                    begin
                        i_reg <= i_reg + 1'b1;
                    end
                end
                gpts_pkg::ST_OUT_A:
                begin
                    result_valid <= 1'b1;
                    if (found_reg)
                    begin
                        gain_reg <= gain1;
                    end
                end
                gpts_pkg::ST_OUT_B:
                begin
                    result_valid <= 1'b1;
                    gain_reg     <= gpts_pkg::sat_add(gain_reg, bkw_reg);
                    agent_x_reg  <= bxw_reg;
                    agent_y_reg  <= byw_reg;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            gpts_pkg::ST_I_CHK:
            begin
                xi_reg <= rdata.x;
                yi_reg <= rdata.y;
                ki_reg <= rdata.w;
                dx_reg <= gpts_pkg::abs_diff(agent_x_reg, rdata.x);
                dy_reg <= gpts_pkg::abs_diff(agent_y_reg, rdata.y);
            end
            gpts_pkg::ST_W_CHK:
            begin
                xw_reg <= rdata.x;
                yw_reg <= rdata.y;
                kw_reg <= rdata.w;
                dx_reg <= gpts_pkg::abs_diff(xi_reg, rdata.x);
                dy_reg <= gpts_pkg::abs_diff(yi_reg, rdata.y);
            end
            gpts_pkg::ST_SQY:
            begin
                sq_reg <= gpts_pkg::SQ_W'(prod);
            end
            gpts_pkg::ST_ROOT:
            begin
                if (sq_done)
                begin
                    if (pair_reg)
                    begin
                        l2_reg <= root;
                    end
                    else
                    begin
                        l1_reg <= root;
                    end
                end
            end
            gpts_pkg::ST_CMP_B:
            begin
                lhs_reg <= prod;
            end
            gpts_pkg::ST_CMP_C:
            begin
                if (better)
                begin
                    best_len_reg <= len;
                    best_k_reg   <= ks;
                    bi_reg       <= i_reg;
                    bw_reg       <= w_reg;
                    bxi_reg      <= xi_reg;
                    byi_reg      <= yi_reg;
                    bki_reg      <= ki_reg;
                    bxw_reg      <= xw_reg;
                    byw_reg      <= yw_reg;
                    bkw_reg      <= kw_reg;
                    bl1_reg      <= l1_reg;
                    bl2_reg      <= l2_reg;
                end
            end
            gpts_pkg::ST_OUT_A:
            begin
                if (found_reg)
                begin
                    result <= '{chosen_index:  gpts_pkg::SLOT_W'(bi_reg),
                                chosen_x:      bxi_reg,
                                chosen_y:      byi_reg,
                                leg_length:    bl1_reg,
                                chosen_weight: bki_reg,
                                gain_so_far:   gain1,
                                status:        gpts_pkg::STATUS_CHOSEN,
                                last:          1'b0};
                end
                else
                begin
                    result <= '{chosen_index:  '0,
                                chosen_x:      '0,
                                chosen_y:      '0,
                                leg_length:    '0,
                                chosen_weight: '0,
                                gain_so_far:   gain_reg,
                                status:        gpts_pkg::STATUS_NO_PAIR,
                                last:          1'b1};
                end
            end
            gpts_pkg::ST_OUT_B:
            begin
                result <= '{chosen_index:  gpts_pkg::SLOT_W'(bw_reg),
                            chosen_x:      bxw_reg,
                            chosen_y:      byw_reg,
                            leg_length:    bl2_reg,
                            chosen_weight: bkw_reg,
                            gain_so_far:   gpts_pkg::sat_add(gain_reg, bkw_reg),
                            status:        gpts_pkg::STATUS_CHOSEN,
                            last:          1'b1};
            end
            default:
            begin
            end
        endcase
    end

endmodule

@@ rtl/gpts_store.sv @@
// Target table: one write port, one registered read port.
// Depends on gpts_pkg.
module gpts_store #(
    parameter int NUM_TARGETS = gpts_pkg::NUM_TARGETS_DEF,
    parameter int IDX_W       = $clog2(NUM_TARGETS)
) (
    input  logic                clk,
    input  logic                we,
    input  logic [IDX_W-1:0]    waddr,
    input  gpts_pkg::entry_t    wdata,
    input  logic [IDX_W-1:0]    raddr,
    output gpts_pkg::entry_t    rdata
);

    gpts_pkg::entry_t mem [NUM_TARGETS];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ rtl/gpts_mul.sv @@
// Shared multiplier with registered product.
// Depends on gpts_pkg.
module gpts_mul (
    input  logic                          clk,
    input  logic [gpts_pkg::MUL_W-1:0]    a,
    input  logic [gpts_pkg::MUL_W-1:0]    b,
    output logic [gpts_pkg::PROD_W-1:0]   prod_reg
);

    always_ff @(posedge clk)
    begin
        prod_reg <= a * b;
    end

endmodule

@@ rtl/gpts_isqrt.sv @@
// Bit-serial integer square root, one root bit per cycle.
// Depends on gpts_pkg.
module gpts_isqrt (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         go,
    input  logic [gpts_pkg::SQ_W-1:0]    radicand,
    output logic                         done_reg,
    output logic [gpts_pkg::LEG_W-1:0]   root_reg
);

    localparam int RW    = gpts_pkg::LEG_W + 3;
    localparam int CNT_W = $clog2(gpts_pkg::LEG_W + 1);

    logic [gpts_pkg::SQ_W-1:0] val_reg;
    logic [RW-1:0]             rem_reg;
    logic [CNT_W-1:0]          cnt_reg;
    logic [RW-1:0]             rem_sh;
    logic [RW-1:0]             test;

    assign rem_sh = {rem_reg[RW-3:0], val_reg[gpts_pkg::SQ_W-1 -: 2]};
    assign test   = RW'({root_reg, 2'b01});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (go)
            begin
                cnt_reg <= CNT_W'(gpts_pkg::LEG_W);
            end
            else if (cnt_reg != '0)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            val_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (cnt_reg != '0)
        begin
            val_reg <= val_reg << 2;
            if (rem_sh >= test)
            begin
                rem_reg  <= rem_sh - test;
                root_reg <= {root_reg[gpts_pkg::LEG_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg  <= rem_sh;
                root_reg <= {root_reg[gpts_pkg::LEG_W-2:0], 1'b0};
            end
        end
    end

endmodule

@@ tb/sv/tb_greedy_pair_target_select_core.sv @@
`timescale 1ns / 1ps
// Testbench for greedy_pair_target_select_core (needs gpts_pkg): a directed table,
// then random load/place/step/unused-kind items, checked by an in-bench predictor.
module tb_greedy_pair_target_select_core;

    localparam int  NSLOT       = 1024;
    localparam int  POOL_N      = 6;
    localparam int  RAND_ITEMS  = 100;
    localparam longint LIMIT    = 6000000;
    localparam logic [1:0] KIND_NONE = 2'd3;

    typedef struct {
        gpts_pkg::in_item_t  cmd;
        bit                  typed;
        gpts_pkg::out_item_t want;
    } dir_row_t;

    logic                clk;
    logic                rst_n;
    logic                start;
    gpts_pkg::in_item_t  cmd;
    logic                busy;
    logic                result_valid;
    gpts_pkg::out_item_t result;

    logic [gpts_pkg::COORD_W-1:0]  tgt_x [NSLOT];
    logic [gpts_pkg::COORD_W-1:0]  tgt_y [NSLOT];
    logic [gpts_pkg::WEIGHT_W-1:0] tgt_w [NSLOT];
    logic [gpts_pkg::COORD_W-1:0]  agt_x, agt_y;
    logic [gpts_pkg::GAIN_W-1:0]   gain;

    gpts_pkg::out_item_t expected_legs[$];
    int        mismatches;
    longint    cycles;

    greedy_pair_target_select_core u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .cmd         (cmd),
        .busy        (busy),
        .result_valid(result_valid),
        .result      (result)
    );

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            cycles <= 0;
        else
            cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    function automatic longint unsigned isqrt(input longint unsigned v);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v)
            b >>= 2;
        while (b != 0)
        begin
            if (v >= res + b)
            begin
                v -= res + b;
                res = (res >> 1) + b;
            end
            else
                res >>= 1;
            b >>= 2;
        end
        return res;
    endfunction

    function automatic longint unsigned leg_len(input logic [gpts_pkg::COORD_W-1:0] ax, ay,
                                                bx, by);
        longint unsigned dx;
        longint unsigned dy;
        dx = (ax > bx) ? ax - bx : bx - ax;
        dy = (ay > by) ? ay - by : by - ay;
        return isqrt(dx * dx + dy * dy);
    endfunction

    function automatic logic [gpts_pkg::GAIN_W-1:0] gain_add(
        input logic [gpts_pkg::GAIN_W-1:0] g,
        input logic [gpts_pkg::WEIGHT_W-1:0] k);
        longint unsigned s;
        s = longint'(g) + k;
        return (s > 64'd1048575) ? {gpts_pkg::GAIN_W{1'b1}} : s[gpts_pkg::GAIN_W-1:0];
    endfunction

    function automatic dir_row_t mk(input logic [1:0] k, input int slot, input int x,
                                    input int y, input int w);
        dir_row_t r;
        r.cmd = '{kind: k, target_slot: slot[gpts_pkg::SLOT_W-1:0],
                  pos_x: x[gpts_pkg::COORD_W-1:0], pos_y: y[gpts_pkg::COORD_W-1:0],
                  weight: w[gpts_pkg::WEIGHT_W-1:0]};
        r.typed = 1'b0;
        r.want = '0;
        return r;
    endfunction

    function automatic dir_row_t no_pair_row(input int g);
        dir_row_t r;
        r = mk(gpts_pkg::KIND_STEP, 0, 0, 0, 0);
        r.typed = 1'b1;
        r.want.gain_so_far = g[gpts_pkg::GAIN_W-1:0];
        r.want.status = gpts_pkg::STATUS_NO_PAIR;
        r.want.last = 1'b1;
        return r;
    endfunction

    task automatic predict_pair_step(input gpts_pkg::in_item_t c, input bit push);
        int live[$];
        longint unsigned first[NSLOT];
        longint unsigned ln, ks, best_len, best_k;
        bit found;
        int bi, bw;
        gpts_pkg::out_item_t r;
        found = 1'b0;
        best_len = 0;
        best_k = 1;
        bi = 0;
        bw = 0;
        r = '0;
        case (c.kind)
            gpts_pkg::KIND_LOAD:
            begin
                tgt_x[c.target_slot] = c.pos_x;
                tgt_y[c.target_slot] = c.pos_y;
                tgt_w[c.target_slot] =
                    (c.weight > gpts_pkg::WEIGHT_W'(gpts_pkg::MAX_WEIGHT_DEF)) ?
                    gpts_pkg::WEIGHT_W'(gpts_pkg::MAX_WEIGHT_DEF) : c.weight;
            end
            gpts_pkg::KIND_PLACE:
            begin
                agt_x = c.pos_x;
                agt_y = c.pos_y;
                gain = '0;
            end
            gpts_pkg::KIND_STEP:
            begin
                for (int i = 0; i < NSLOT; i++)
                    if (tgt_w[i] != 0)
                    begin
                        live.push_back(i);
                        first[i] = leg_len(agt_x, agt_y, tgt_x[i], tgt_y[i]);
                    end
                foreach (live[a])
                    foreach (live[b])
                        if (a != b)
                        begin
                            ln = first[live[a]] + leg_len(tgt_x[live[a]], tgt_y[live[a]],
                                                          tgt_x[live[b]], tgt_y[live[b]]);
                            ks = tgt_w[live[a]] + tgt_w[live[b]];
                            if (!found || ln * best_k < best_len * ks)
                            begin
                                found = 1'b1;
                                best_len = ln;
                                best_k = ks;
                                bi = live[a];
                                bw = live[b];
                            end
                        end
                if (!found)
                begin
                    r.gain_so_far = gain;
                    r.status = gpts_pkg::STATUS_NO_PAIR;
                    r.last = 1'b1;
                    if (push)
                        expected_legs.push_back(r);
                end
                else
                begin
                    gain = gain_add(gain, tgt_w[bi]);
                    r = '{chosen_index: bi[gpts_pkg::SLOT_W-1:0], chosen_x: tgt_x[bi],
                          chosen_y: tgt_y[bi], leg_length: first[bi][gpts_pkg::LEG_W-1:0],
                          chosen_weight: tgt_w[bi], gain_so_far: gain,
                          status: gpts_pkg::STATUS_CHOSEN, last: 1'b0};
                    if (push)
                        expected_legs.push_back(r);
                    gain = gain_add(gain, tgt_w[bw]);
                    ln = leg_len(tgt_x[bi], tgt_y[bi], tgt_x[bw], tgt_y[bw]);
                    r = '{chosen_index: bw[gpts_pkg::SLOT_W-1:0], chosen_x: tgt_x[bw],
                          chosen_y: tgt_y[bw], leg_length: ln[gpts_pkg::LEG_W-1:0],
                          chosen_weight: tgt_w[bw], gain_so_far: gain,
                          status: gpts_pkg::STATUS_CHOSEN, last: 1'b1};
                    if (push)
                        expected_legs.push_back(r);
                    agt_x = tgt_x[bw];
                    agt_y = tgt_y[bw];
                    tgt_w[bi] = '0;
                    tgt_w[bw] = '0;
                end
            end
            default:
            begin
            end
        endcase
    endtask

    // drive at the falling edge; busy seen there holds through the next rising edge
    task automatic send_item(input gpts_pkg::in_item_t c, input int gap);
        repeat (gap)
        begin
            @(negedge clk);
            start <= 1'b0;
        end
        @(negedge clk);
        start <= 1'b1;
        cmd <= c;
        #0;
        while (busy)
            @(negedge clk);
        @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && result_valid)
        begin
            if (expected_legs.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %p", result);
            end
            else
            begin
                gpts_pkg::out_item_t e;
                e = expected_legs.pop_front();
                if (result !== e)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %p actual %p", e, result);
                end
            end
        end
    end

    initial
    begin
        dir_row_t rows[$];
        int pool[POOL_N];
        int pct[4];
        int gap, sel, wait_cnt;
        gpts_pkg::in_item_t c;

        rst_n = 1'b0;
        start = 1'b0;
        cmd = '0;
        mismatches = 0;
        for (int i = 0; i < NSLOT; i++)
        begin
            tgt_x[i] = '0;
            tgt_y[i] = '0;
            tgt_w[i] = '0;
        end
        agt_x = gpts_pkg::AGENT_RESET;
        agt_y = gpts_pkg::AGENT_RESET;
        gain = '0;

        rows.push_back(no_pair_row(0));
        rows.push_back(mk(KIND_NONE, 1023, 65535, 65535, 1023));
        rows.push_back(mk(gpts_pkg::KIND_LOAD, 0, 0, 0, 1023));
        rows.push_back(mk(gpts_pkg::KIND_LOAD, 1023, 65535, 65535, 1));
        rows.push_back(mk(gpts_pkg::KIND_STEP, 0, 0, 0, 0));
        rows.push_back(no_pair_row(1001));
        rows.push_back(mk(gpts_pkg::KIND_LOAD, 5, 100, 0, 7));
        rows.push_back(mk(gpts_pkg::KIND_LOAD, 9, 0, 100, 7));
        rows.push_back(mk(gpts_pkg::KIND_PLACE, 0, 0, 0, 0));
        rows.push_back(mk(gpts_pkg::KIND_STEP, 0, 0, 0, 0));
        rows.push_back(no_pair_row(14));
        rows.push_back(mk(gpts_pkg::KIND_LOAD, 341, 1, 2, 1000));
        rows.push_back(mk(gpts_pkg::KIND_LOAD, 682, 40000, 20000, 512));
        rows.push_back(mk(gpts_pkg::KIND_LOAD, 100, 3, 4, 9));
        rows.push_back(mk(gpts_pkg::KIND_LOAD, 100, 3, 4, 0));
        rows.push_back(mk(gpts_pkg::KIND_PLACE, 0, 65535, 0, 0));
        rows.push_back(mk(gpts_pkg::KIND_STEP, 0, 0, 0, 0));
        rows.push_back(mk(gpts_pkg::KIND_PLACE, 0, 43690, 21845, 0));
        rows.push_back(no_pair_row(0));

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (rows[r])
        begin
            send_item(rows[r].cmd, 0);
            predict_pair_step(rows[r].cmd, !rows[r].typed);
            if (rows[r].typed)
                expected_legs.push_back(rows[r].want);
        end

        for (int p = 0; p < POOL_N; p++)
            pool[p] = $urandom_range(0, NSLOT - 1);
        pct = '{0, 66, 0, 37};
        for (int n = 0; n < RAND_ITEMS; n++)
        begin
            gap = 0;
            while ($urandom_range(0, 99) < pct[n * 4 / RAND_ITEMS] && gap < 20)
                gap++;
            c.pos_x = gpts_pkg::COORD_W'($urandom());
            c.pos_y = gpts_pkg::COORD_W'($urandom());
            c.weight = gpts_pkg::WEIGHT_W'($urandom_range(0, 1023));
            c.target_slot = gpts_pkg::SLOT_W'(pool[$urandom_range(0, POOL_N - 1)]);
            sel = $urandom_range(0, 99);
            if (sel < 45)
            begin
                c.kind = gpts_pkg::KIND_LOAD;
                if ($urandom_range(0, 9) == 0)
                    c.weight = '0;
            end
            else if (sel < 55)
            begin
                c.kind = gpts_pkg::KIND_LOAD;
                c.target_slot = gpts_pkg::SLOT_W'($urandom());
                c.weight = '0;
            end
            else if (sel < 85)
                c.kind = gpts_pkg::KIND_STEP;
            else if (sel < 95)
                c.kind = gpts_pkg::KIND_PLACE;
            else
                c.kind = KIND_NONE;
            send_item(c, gap);
            predict_pair_step(c, 1'b1);
        end
        @(negedge clk);
        start <= 1'b0;

        wait_cnt = 0;
        while (expected_legs.size() != 0 && wait_cnt < 200000)
        begin
            @(posedge clk);
            wait_cnt++;
        end
        repeat (100) @(posedge clk);
        if (mismatches == 0 && expected_legs.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule

@@ filelist.f @@
rtl/gpts_pkg.sv
rtl/gpts_store.sv
rtl/gpts_mul.sv
rtl/gpts_isqrt.sv
rtl/greedy_pair_target_select_core.sv
tb/sv/tb_greedy_pair_target_select_core.sv
